@@ rtl/core/gbe_pkg.sv @@
package gbe_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int TIME_W     = 32;
  localparam int COUNT_BITS = 20;
  localparam int MINCNT_W   = 20;
  localparam int RATE_W     = 17;
  localparam int THRESH_W   = 23;
  localparam int NUM_REGS   = 7;
  localparam int ADDR_W     = 5;
  localparam int JUMP_MS    = 3000;
  localparam int Q16_ONE    = 65536;

  typedef enum logic [1:0] {
    KIND_GYRO  = 2'd0,
    KIND_ODOM  = 2'd1,
    KIND_RESET = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_CALIB  = 2'd0,
    MODE_MOVING = 2'd1,
    MODE_JUST   = 2'd2,
    MODE_LONG   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_CALIB_DUR  = 3'd0,
    REG_MIN_SAMP   = 3'd1,
    REG_EMA_RATE   = 3'd2,
    REG_GYRO_TH    = 3'd3,
    REG_VEL_TH     = 3'd4,
    REG_STILL_DUR  = 3'd5,
    REG_SKIP_CALIB = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_JUMP,
    ST_ACCUM,
    ST_CHECK,
    ST_DIV,
    ST_DIVEND,
    ST_MUL,
    ST_EMA,
    ST_CORR,
    ST_ODO1,
    ST_ODO2,
    ST_ODO3,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [TIME_W-1:0]          sample_time;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
    logic signed [SAMPLE_W-1:0] lin_vel_x;
    logic signed [SAMPLE_W-1:0] lin_vel_y;
    logic signed [SAMPLE_W-1:0] lin_vel_z;
    logic signed [SAMPLE_W-1:0] ang_vel_x;
    logic signed [SAMPLE_W-1:0] ang_vel_y;
    logic signed [SAMPLE_W-1:0] ang_vel_z;
  } in_item_t;

  typedef struct packed {
    logic                       corrected_valid;
    logic signed [SAMPLE_W-1:0] corrected_x;
    logic signed [SAMPLE_W-1:0] corrected_y;
    logic signed [SAMPLE_W-1:0] corrected_z;
    logic                       bias_valid;
    logic signed [SAMPLE_W-1:0] bias_x;
    logic signed [SAMPLE_W-1:0] bias_y;
    logic signed [SAMPLE_W-1:0] bias_z;
    logic [1:0]                 mode;
    logic                       calib_disturbed;
  } out_item_t;

endpackage

@@ rtl/core/gyro_bias_estimator_core.sv @@
// Each request walks the sequencer from idle to the done state: an unknown kind goes there
// directly, a reset passes CLEAR, odometry passes ODO1, ODO2 and, when still in the just-stopped
// or long-still mode, ODO3, and a gyro sample passes JUMP, ACCUM, CHECK and CORR, with MUL and EMA
// before CORR when the bias average is updated, or with the bit-serial divider that forms the
// calibration average (one quotient bit a cycle) and DIVEND when the request ends calibration.
// Requests are taken one at a time; the input stalls until the last result is in the output register.
// Reset (rst_ni low, asynchronous) clears all run state, puts the mode in calibration and
// loads the register defaults.
module gyro_bias_estimator_core #(
  parameter int COUNT_BITS = gbe_pkg::COUNT_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gbe_pkg::in_item_t           in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gbe_pkg::out_item_t          out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbe_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int SW     = gbe_pkg::SAMPLE_W;
  localparam int TW     = gbe_pkg::TIME_W;
  localparam int ACC_W  = SW + COUNT_BITS;
  localparam int NW     = (COUNT_BITS > gbe_pkg::MINCNT_W) ? COUNT_BITS : gbe_pkg::MINCNT_W;
  localparam int DCNT_W = $clog2(ACC_W + 1);
  localparam int DIF_W  = SW + 2;
  localparam int PW     = gbe_pkg::RATE_W + 1 + DIF_W;
  localparam int TH_W   = gbe_pkg::THRESH_W;

  // Configuration registers.
  logic [TW-1:0]                    calib_dur_q, still_dur_q;
  logic [gbe_pkg::MINCNT_W-1:0]     min_samp_q;
  logic [gbe_pkg::RATE_W-1:0]       ema_rate_q;
  logic [TH_W-1:0]                  gyro_th_q, vel_th_q;
  logic                             skip_q;
  gbe_pkg::reg_e                    reg_idx;
  logic                             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = gbe_pkg::reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      gbe_pkg::REG_CALIB_DUR:  prdata = calib_dur_q;
      gbe_pkg::REG_MIN_SAMP:   prdata = 32'(min_samp_q);
      gbe_pkg::REG_EMA_RATE:   prdata = 32'(ema_rate_q);
      gbe_pkg::REG_GYRO_TH:    prdata = 32'(gyro_th_q);
      gbe_pkg::REG_VEL_TH:     prdata = 32'(vel_th_q);
      gbe_pkg::REG_STILL_DUR:  prdata = still_dur_q;
      gbe_pkg::REG_SKIP_CALIB: prdata = 32'(skip_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_dur_q <= TW'(15000);
      min_samp_q  <= gbe_pkg::MINCNT_W'(1000);
      ema_rate_q  <= gbe_pkg::RATE_W'(655);
      gyro_th_q   <= TH_W'(3277);
      vel_th_q    <= TH_W'(66);
      still_dur_q <= TW'(2000);
      skip_q      <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        gbe_pkg::REG_CALIB_DUR:  calib_dur_q <= pwdata[TW-1:0];
        gbe_pkg::REG_MIN_SAMP:   min_samp_q  <= pwdata[gbe_pkg::MINCNT_W-1:0];
        gbe_pkg::REG_EMA_RATE:   ema_rate_q  <= pwdata[gbe_pkg::RATE_W-1:0];
        gbe_pkg::REG_GYRO_TH:    gyro_th_q   <= pwdata[TH_W-1:0];
        gbe_pkg::REG_VEL_TH:     vel_th_q    <= pwdata[TH_W-1:0];
        gbe_pkg::REG_STILL_DUR:  still_dur_q <= pwdata[TW-1:0];
        gbe_pkg::REG_SKIP_CALIB: skip_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer state and run state.
  gbe_pkg::state_e             state_q, state_d;
  gbe_pkg::mode_e              mode_q;
  gbe_pkg::in_item_t           in_q;
  logic signed [ACC_W-1:0]     acc_q [3];
  logic [COUNT_BITS-1:0]       count_q;
  logic [TW-1:0]               calib_start_q, still_q, stamp_q, arrival_q;
  logic                        bias_v_q, corr_v_q, dist_q, odo_mov_q, fwd_q;
  logic [TW-1:0]               dt_q;
  logic signed [SW-1:0]        corr_q [3];
  logic [DCNT_W-1:0]           dcnt_q;
  logic [COUNT_BITS-1:0]       rem_q [3];
  logic [ACC_W-1:0]            quo_q [3];
  logic                        neg_q [3];
  logic signed [PW-1:0]        prod_q [3];
  logic                        out_valid_q;
  gbe_pkg::out_item_t          out_q;

  logic signed [SW-1:0]        w [3];
  logic signed [SW-1:0]        v [6];
  logic signed [ACC_W:0]       dw [3];
  logic                        over_th, vel_mov, calib_done, out_free;
  logic [TW:0]                 jump_sum, t_fwd, t_bwd, still_add, elapsed;
  logic signed [ACC_W-1:0]     step [3];
  logic [COUNT_BITS:0]         trial [3];

  function automatic logic signed [SW-1:0] sat_s(input logic signed [ACC_W:0] x);
    logic signed [ACC_W:0] hi, lo;
    begin
      hi = (ACC_W+1)'({1'b0, {(SW-1){1'b1}}});
      lo = -hi - 1;
      if (x > hi)      sat_s = {1'b0, {(SW-1){1'b1}}};
      else if (x < lo) sat_s = {1'b1, {(SW-1){1'b0}}};
      else             sat_s = x[SW-1:0];
    end
  endfunction

  function automatic logic [ACC_W:0] mag_a(input logic signed [ACC_W:0] x);
    begin
      mag_a = x[ACC_W] ? -x : x;
    end
  endfunction

  assign w[0] = in_q.gyro_x;
  assign w[1] = in_q.gyro_y;
  assign w[2] = in_q.gyro_z;
  assign v[0] = in_q.lin_vel_x;
  assign v[1] = in_q.lin_vel_y;
  assign v[2] = in_q.lin_vel_z;
  assign v[3] = in_q.ang_vel_x;
  assign v[4] = in_q.ang_vel_y;
  assign v[5] = in_q.ang_vel_z;

  always_comb begin
    over_th = 1'b0;
    for (int a = 0; a < 3; a++) begin
      dw[a] = (ACC_W+1)'(w[a]) - (ACC_W+1)'(acc_q[a]);
      if (mag_a(dw[a]) > (ACC_W+1)'(gyro_th_q)) over_th = 1'b1;
      step[a] = ACC_W'((prod_q[a] + PW'(gbe_pkg::Q16_ONE / 2)) >>> 16);
      trial[a] = {rem_q[a], quo_q[a][ACC_W-1]};
    end
    vel_mov = 1'b0;
    for (int k = 0; k < 6; k++) begin
      if ((v[k][SW-1] ? -(SW+1)'(v[k]) : (SW+1)'(v[k])) > (SW+1)'(vel_th_q)) vel_mov = 1'b1;
    end
  end

  assign jump_sum   = (TW+1)'(in_q.sample_time) + (TW+1)'(gbe_pkg::JUMP_MS);
  assign elapsed    = {1'b0, in_q.sample_time} - {1'b0, calib_start_q};
  // Calibration ends once enough samples are summed and enough time has passed.
  assign calib_done = (NW'(count_q) >= NW'(min_samp_q)) && (count_q != '0) &&
                      !elapsed[TW] && (elapsed[TW-1:0] >= calib_dur_q);
  assign t_fwd      = {1'b0, in_q.sample_time} - {1'b0, stamp_q};
  assign t_bwd      = {1'b0, stamp_q} - {1'b0, in_q.sample_time};
  assign still_add  = {1'b0, still_q} + {1'b0, dt_q};
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != gbe_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= gbe_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gbe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (gbe_pkg::kind_e'(in_i.kind))
            gbe_pkg::KIND_GYRO:  state_d = gbe_pkg::ST_JUMP;
            gbe_pkg::KIND_ODOM:  state_d = gbe_pkg::ST_ODO1;
            gbe_pkg::KIND_RESET: state_d = gbe_pkg::ST_CLEAR;
            default:             state_d = gbe_pkg::ST_DONE;
          endcase
        end
      end
      gbe_pkg::ST_JUMP:  state_d = gbe_pkg::ST_ACCUM;
      gbe_pkg::ST_ACCUM: state_d = gbe_pkg::ST_CHECK;
      gbe_pkg::ST_CHECK: begin
        if (mode_q == gbe_pkg::MODE_CALIB && calib_done)   state_d = gbe_pkg::ST_DIV;
        else if (mode_q == gbe_pkg::MODE_LONG && !over_th) state_d = gbe_pkg::ST_MUL;
        else                                              state_d = gbe_pkg::ST_CORR;
      end
      gbe_pkg::ST_DIV: begin
        if (dcnt_q == DCNT_W'(ACC_W - 1)) state_d = gbe_pkg::ST_DIVEND;
      end
      gbe_pkg::ST_DIVEND: state_d = gbe_pkg::ST_CORR;
      gbe_pkg::ST_MUL:    state_d = gbe_pkg::ST_EMA;
      gbe_pkg::ST_EMA:    state_d = gbe_pkg::ST_CORR;
      gbe_pkg::ST_CORR:   state_d = gbe_pkg::ST_DONE;
      gbe_pkg::ST_ODO1:   state_d = gbe_pkg::ST_ODO2;
      gbe_pkg::ST_ODO2: begin
        if (!odo_mov_q && mode_q != gbe_pkg::MODE_MOVING && mode_q != gbe_pkg::MODE_CALIB)
          state_d = gbe_pkg::ST_ODO3;
        else
          state_d = gbe_pkg::ST_DONE;
      end
      gbe_pkg::ST_ODO3:  state_d = gbe_pkg::ST_DONE;
      gbe_pkg::ST_CLEAR: state_d = gbe_pkg::ST_DONE;
      gbe_pkg::ST_DONE: begin
        if (out_free) state_d = gbe_pkg::ST_IDLE;
      end
      default: state_d = gbe_pkg::ST_IDLE;
    endcase
  end

  // Run state and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= gbe_pkg::MODE_CALIB;
      for (int a = 0; a < 3; a++) acc_q[a] <= '0;
      count_q       <= '0;
      calib_start_q <= '0;
      still_q       <= '0;
      stamp_q       <= '0;
      arrival_q     <= '0;
      bias_v_q      <= 1'b0;
      corr_v_q      <= 1'b0;
      dist_q        <= 1'b0;
      odo_mov_q     <= 1'b0;
      dcnt_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // The output register is loaded from the done state and emptied when taken.
      if (state_q == gbe_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i)      out_valid_q <= 1'b0;
      case (state_q)
        gbe_pkg::ST_IDLE: begin
          bias_v_q <= 1'b0;
          corr_v_q <= 1'b0;
          dist_q   <= 1'b0;
        end
        gbe_pkg::ST_JUMP: begin
          // A time stamp far behind the last one restarts the run.
          if (jump_sum < {1'b0, arrival_q}) begin
            mode_q        <= skip_q ? gbe_pkg::MODE_MOVING : gbe_pkg::MODE_CALIB;
            for (int a = 0; a < 3; a++) acc_q[a] <= '0;
            count_q       <= '0;
            still_q       <= '0;
            stamp_q       <= '0;
            calib_start_q <= in_q.sample_time;
          end
          arrival_q <= in_q.sample_time;
        end
        gbe_pkg::ST_ACCUM: begin
          // The count saturates; samples past the cap are not summed.
          if (mode_q == gbe_pkg::MODE_CALIB && count_q != '1) begin
            for (int a = 0; a < 3; a++) acc_q[a] <= acc_q[a] + ACC_W'(w[a]);
            count_q <= count_q + 1'b1;
          end
        end
        gbe_pkg::ST_CHECK: begin
          dcnt_q <= '0;
          if (mode_q == gbe_pkg::MODE_LONG && over_th) begin
            mode_q  <= gbe_pkg::MODE_MOVING;
            stamp_q <= '0;
            still_q <= '0;
          end
        end
        gbe_pkg::ST_DIV: dcnt_q <= dcnt_q + 1'b1;
        gbe_pkg::ST_DIVEND: begin
          for (int a = 0; a < 3; a++) acc_q[a] <= neg_q[a] ? -$signed(quo_q[a]) : $signed(quo_q[a]);
          bias_v_q <= 1'b1;
          if (stamp_q == '0)              mode_q <= gbe_pkg::MODE_MOVING;
          else if (still_q >= still_dur_q) mode_q <= gbe_pkg::MODE_LONG;
          else                            mode_q <= gbe_pkg::MODE_JUST;
        end
        gbe_pkg::ST_EMA: begin
          for (int a = 0; a < 3; a++) acc_q[a] <= acc_q[a] + step[a];
          bias_v_q <= 1'b1;
        end
        gbe_pkg::ST_CORR: corr_v_q <= (mode_q != gbe_pkg::MODE_CALIB);
        gbe_pkg::ST_ODO1: odo_mov_q <= vel_mov;
        gbe_pkg::ST_ODO2: begin
          if (odo_mov_q) begin
            if (mode_q == gbe_pkg::MODE_CALIB) dist_q <= 1'b1;
            else                               mode_q <= gbe_pkg::MODE_MOVING;
            still_q <= '0;
            stamp_q <= '0;
          end else if (mode_q == gbe_pkg::MODE_MOVING) begin
            mode_q  <= gbe_pkg::MODE_JUST;
            stamp_q <= in_q.sample_time;
            still_q <= '0;
          end else begin
            // Still time grows by the stamp step, saturating, and shrinks on a step back.
            if (stamp_q != '0) begin
              if (fwd_q)                 still_q <= still_add[TW] ? '1 : still_add[TW-1:0];
              else if (dt_q > still_q)   still_q <= '0;
              else                       still_q <= still_q - dt_q;
            end
            stamp_q <= in_q.sample_time;
          end
        end
        gbe_pkg::ST_ODO3: begin
          mode_q <= (still_q > still_dur_q) ? gbe_pkg::MODE_LONG : gbe_pkg::MODE_JUST;
        end
        gbe_pkg::ST_CLEAR: begin
          mode_q        <= skip_q ? gbe_pkg::MODE_MOVING : gbe_pkg::MODE_CALIB;
          for (int a = 0; a < 3; a++) acc_q[a] <= '0;
          count_q       <= '0;
          still_q       <= '0;
          stamp_q       <= '0;
          calib_start_q <= in_q.sample_time;
        end
        default: ;
      endcase
    end
  end

  // Payload: the request, the divider, the products and the result.
  always_ff @(posedge clk_i) begin
    if (state_q == gbe_pkg::ST_IDLE && in_valid_i) in_q <= in_i;
    if (state_q == gbe_pkg::ST_ODO1) begin
      fwd_q <= !t_fwd[TW];
      dt_q  <= t_fwd[TW] ? t_bwd[TW-1:0] : t_fwd[TW-1:0];
    end
    for (int a = 0; a < 3; a++) begin
      if (state_q == gbe_pkg::ST_CHECK) begin
        // Magnitudes are divided; the sign is put back afterwards.
        neg_q[a] <= acc_q[a][ACC_W-1];
        quo_q[a] <= acc_q[a][ACC_W-1] ? ACC_W'(-acc_q[a]) : ACC_W'(acc_q[a]);
        rem_q[a] <= '0;
      end else if (state_q == gbe_pkg::ST_DIV) begin
        if (trial[a] >= {1'b0, count_q}) begin
          rem_q[a] <= COUNT_BITS'(trial[a] - {1'b0, count_q});
          quo_q[a] <= {quo_q[a][ACC_W-2:0], 1'b1};
        end else begin
          rem_q[a] <= trial[a][COUNT_BITS-1:0];
          quo_q[a] <= {quo_q[a][ACC_W-2:0], 1'b0};
        end
      end
      if (state_q == gbe_pkg::ST_MUL) begin
        prod_q[a] <= PW'($signed({1'b0, (ema_rate_q > gbe_pkg::RATE_W'(gbe_pkg::Q16_ONE))
                                       ? gbe_pkg::RATE_W'(gbe_pkg::Q16_ONE) : ema_rate_q}) *
                         $signed(dw[a][DIF_W-1:0]));
      end
      if (state_q == gbe_pkg::ST_CORR) begin
        corr_q[a] <= (mode_q != gbe_pkg::MODE_CALIB) ? sat_s(dw[a]) : '0;
      end
    end
    if (state_q == gbe_pkg::ST_DONE && out_free) begin
      out_q.corrected_valid <= corr_v_q;
      out_q.corrected_x     <= corr_v_q ? corr_q[0] : '0;
      out_q.corrected_y     <= corr_v_q ? corr_q[1] : '0;
      out_q.corrected_z     <= corr_v_q ? corr_q[2] : '0;
      out_q.bias_valid      <= bias_v_q;
      out_q.bias_x          <= (mode_q == gbe_pkg::MODE_CALIB) ? '0 : sat_s((ACC_W+1)'(acc_q[0]));
      out_q.bias_y          <= (mode_q == gbe_pkg::MODE_CALIB) ? '0 : sat_s((ACC_W+1)'(acc_q[1]));
      out_q.bias_z          <= (mode_q == gbe_pkg::MODE_CALIB) ? '0 : sat_s((ACC_W+1)'(acc_q[2]));
      out_q.mode            <= mode_q;
      out_q.calib_disturbed <= dist_q;
    end
  end

`ifndef SYNTHESIS
  // A corrected sample is only produced outside calibration.
  a_corr_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.corrected_valid |-> out_o.mode != gbe_pkg::MODE_CALIB)
    else $error("corrected sample reported during calibration");

  // The bias reads as zero while calibrating.
  a_bias_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.mode == gbe_pkg::MODE_CALIB |->
      out_o.bias_x == '0 && out_o.bias_y == '0 && out_o.bias_z == '0)
    else $error("bias reported during calibration");

  // The divider never runs with an empty count.
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gbe_pkg::ST_DIV |-> count_q != '0)
    else $error("divider started with a zero count");

  // Disturbance is only flagged while calibrating.
  a_dist_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.calib_disturbed |-> out_o.mode == gbe_pkg::MODE_CALIB)
    else $error("disturbance flagged outside calibration");
`endif

endmodule

@@ tb/tb_gyro_bias_estimator_core.sv @@
module tb_gyro_bias_estimator_core;
  import gbe_pkg::*;

  localparam longint unsigned COUNT_CAP = (64'd1 << COUNT_BITS) - 1;
  localparam longint unsigned TIME_MAX  = 64'hFFFF_FFFF;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gyro_bias_estimator_core u_top (.*);

  // Clock with period 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the block's configuration registers.
  longint unsigned cfg_cal_dur, cfg_min_samp, cfg_rate, cfg_gyro_th, cfg_vel_th;
  longint unsigned cfg_still_dur, cfg_skip;

  // Predicted run state of the estimator.
  mode_e           est_mode;
  longint          est_acc[3];
  longint unsigned est_count, est_cal_start, est_still_time, est_still_stamp, est_last_arrival;

  // Results still owed by the block, oldest first.
  out_item_t pending_results[$];
  int        mismatches = 0;
  int        cycles = 0;

  // Idling controls shared by the sender, the receiver and the tests.
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  // Stimulus generation state: current time stamp and the bias that the
  // synthetic gyro hovers around.
  longint unsigned stamp_now = 100;
  int gyro_base[3] = '{0, 0, 0};

  // The watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: a long hold-off takes precedence over the random stall.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i = 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] sat24(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic longint abs_val(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic restart_run(longint unsigned now);
    est_mode = cfg_skip ? MODE_MOVING : MODE_CALIB;
    est_count = 0;
    est_acc = '{0, 0, 0};
    est_still_time = 0;
    est_still_stamp = 0;
    est_cal_start = now;
  endtask

  // Computes the one result that a request causes and advances the state.
  task automatic estimate(input in_item_t r, output out_item_t res);
    longint          g[3];
    longint          corr[3];
    longint          vel[6];
    longint          rate;
    longint unsigned now, d;
    bit              corr_ok, bias_ok, disturbed, moving;
    now = r.sample_time;
    g[0] = r.gyro_x;
    g[1] = r.gyro_y;
    g[2] = r.gyro_z;
    vel = '{r.lin_vel_x, r.lin_vel_y, r.lin_vel_z, r.ang_vel_x, r.ang_vel_y, r.ang_vel_z};
    corr = '{0, 0, 0};
    corr_ok = 0;
    bias_ok = 0;
    disturbed = 0;
    case (kind_e'(r.kind))
      KIND_GYRO: begin
        // A time stamp far in the past restarts the whole run.
        if (now + JUMP_MS < est_last_arrival) restart_run(now);
        est_last_arrival = now;
        if (est_mode == MODE_CALIB) begin
          if (est_count < COUNT_CAP) begin
            for (int i = 0; i < 3; i++) est_acc[i] += g[i];
            est_count++;
          end
          if (est_count >= cfg_min_samp && est_count != 0 && now >= est_cal_start &&
              now - est_cal_start >= cfg_cal_dur) begin
            for (int i = 0; i < 3; i++) est_acc[i] = est_acc[i] / longint'(est_count);
            bias_ok = 1;
            if (est_still_stamp == 0) est_mode = MODE_MOVING;
            else if (est_still_time >= cfg_still_dur) est_mode = MODE_LONG;
            else est_mode = MODE_JUST;
          end
        end else if (est_mode == MODE_LONG) begin
          if (abs_val(g[0] - est_acc[0]) > longint'(cfg_gyro_th) ||
              abs_val(g[1] - est_acc[1]) > longint'(cfg_gyro_th) ||
              abs_val(g[2] - est_acc[2]) > longint'(cfg_gyro_th)) begin
            est_mode = MODE_MOVING;
            est_still_stamp = 0;
            est_still_time = 0;
          end else begin
            rate = cfg_rate > Q16_ONE ? Q16_ONE : longint'(cfg_rate);
            for (int i = 0; i < 3; i++)
              est_acc[i] += (rate * (g[i] - est_acc[i]) + Q16_ONE / 2) >>> 16;
            bias_ok = 1;
          end
        end
        if (est_mode != MODE_CALIB) begin
          corr_ok = 1;
          for (int i = 0; i < 3; i++) corr[i] = g[i] - est_acc[i];
        end
      end
      KIND_ODOM: begin
        moving = 0;
        for (int i = 0; i < 6; i++)
          if (abs_val(vel[i]) > longint'(cfg_vel_th)) moving = 1;
        if (moving) begin
          if (est_mode == MODE_CALIB) disturbed = 1;
          else est_mode = MODE_MOVING;
          est_still_time = 0;
          est_still_stamp = 0;
        end else if (est_mode == MODE_MOVING) begin
          est_mode = MODE_JUST;
          est_still_stamp = now;
          est_still_time = 0;
        end else begin
          // Stillness accumulates only once a previous still stamp exists.
          if (est_still_stamp != 0) begin
            if (now >= est_still_stamp) begin
              d = now - est_still_stamp;
              est_still_time = (d > TIME_MAX - est_still_time) ? TIME_MAX : est_still_time + d;
            end else begin
              d = est_still_stamp - now;
              est_still_time = (d > est_still_time) ? 0 : est_still_time - d;
            end
          end
          est_still_stamp = now;
          if (est_mode != MODE_CALIB)
            est_mode = (est_still_time > cfg_still_dur) ? MODE_LONG : MODE_JUST;
        end
      end
      KIND_RESET: restart_run(now);
      default: ;
    endcase
    res.corrected_valid = corr_ok;
    res.corrected_x = sat24(corr[0]);
    res.corrected_y = sat24(corr[1]);
    res.corrected_z = sat24(corr[2]);
    res.bias_valid = bias_ok;
    res.bias_x = (est_mode == MODE_CALIB) ? '0 : sat24(est_acc[0]);
    res.bias_y = (est_mode == MODE_CALIB) ? '0 : sat24(est_acc[1]);
    res.bias_z = (est_mode == MODE_CALIB) ? '0 : sat24(est_acc[2]);
    res.mode = est_mode;
    res.calib_disturbed = disturbed;
  endtask

  // Result checker: every accepted result must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_o);
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        if (out_o.corrected_valid !== want.corrected_valid ||
            out_o.corrected_x !== want.corrected_x ||
            out_o.corrected_y !== want.corrected_y ||
            out_o.corrected_z !== want.corrected_z ||
            out_o.bias_valid !== want.bias_valid ||
            out_o.bias_x !== want.bias_x || out_o.bias_y !== want.bias_y ||
            out_o.bias_z !== want.bias_z || out_o.mode !== want.mode ||
            out_o.calib_disturbed !== want.calib_disturbed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch\n  expected %p\n  actual   %p", want, out_o);
        end
      end
    end
  end

  // Sends one request; the prediction is made when the block accepts it.
  task automatic send_request(input in_item_t r);
    out_item_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_i = r;
    do @(posedge clk_i); while (in_stall_o);
    estimate(r, res);
    pending_results.push_back(res);
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Register write over the APB port; the block must be idle.
  task automatic write_reg(input reg_e idx, input longint unsigned value);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = ADDR_W'(4 * int'(idx));
    pwdata = value[31:0];
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_CALIB_DUR:  cfg_cal_dur   = value[31:0];
      REG_MIN_SAMP:   cfg_min_samp  = value[MINCNT_W-1:0];
      REG_EMA_RATE:   cfg_rate      = value[RATE_W-1:0];
      REG_GYRO_TH:    cfg_gyro_th   = value[THRESH_W-1:0];
      REG_VEL_TH:     cfg_vel_th    = value[THRESH_W-1:0];
      REG_STILL_DUR:  cfg_still_dur = value[31:0];
      REG_SKIP_CALIB: cfg_skip      = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input longint unsigned cal_dur, min_samp, rate, gyro_th, vel_th,
                           still_dur, skip);
    write_reg(REG_CALIB_DUR, cal_dur);
    write_reg(REG_MIN_SAMP, min_samp);
    write_reg(REG_EMA_RATE, rate);
    write_reg(REG_GYRO_TH, gyro_th);
    write_reg(REG_VEL_TH, vel_th);
    write_reg(REG_STILL_DUR, still_dur);
    write_reg(REG_SKIP_CALIB, skip);
  endtask

  function automatic in_item_t make_item(kind_e k, longint unsigned t);
    in_item_t r;
    r = '0;
    r.kind = k;
    r.sample_time = t[31:0];
    return r;
  endfunction

  function automatic in_item_t gyro_item(longint unsigned t, int x, int y, int z);
    in_item_t r;
    r = make_item(KIND_GYRO, t);
    r.gyro_x = x[23:0];
    r.gyro_y = y[23:0];
    r.gyro_z = z[23:0];
    return r;
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Random request. Most requests follow a plausible timeline: gyro samples
  // near a slowly chosen bias and odometry that is mostly still. The rest are
  // resets, unknown kinds, time jumps and fully random fields.
  function automatic in_item_t random_item();
    in_item_t r;
    int       sel, span;
    sel = $urandom_range(99);
    stamp_now += $urandom_range(0, 12);
    if ($urandom_range(99) < 2) stamp_now = (stamp_now > 4000) ? stamp_now - 3500 - $urandom_range(500)
                                                                : stamp_now;
    stamp_now &= TIME_MAX;
    if (sel < 8) begin
      r = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom});
      if ($urandom_range(1)) r.sample_time = stamp_now[31:0];
    end else if (sel < 12) begin
      r = make_item(KIND_RESET, stamp_now);
    end else if (sel < 14) begin
      r = make_item(KIND_NONE, stamp_now);
    end else if (sel < 62) begin
      // The noise mostly stays inside the motion threshold.
      span = (cfg_gyro_th > 4000) ? 4000 : int'(cfg_gyro_th);
      if ($urandom_range(99) < 8) span = span * 3 + 10;
      r = gyro_item(stamp_now, gyro_base[0] + jitter(span), gyro_base[1] + jitter(span),
                    gyro_base[2] + jitter(span));
    end else begin
      r = make_item(KIND_ODOM, stamp_now);
      span = (cfg_vel_th > 4000) ? 4000 : int'(cfg_vel_th);
      if ($urandom_range(99) < 20) span = span * 2 + 5;
      r.lin_vel_x = 24'(jitter(span));
      r.lin_vel_y = 24'(jitter(span));
      r.lin_vel_z = 24'(jitter(span));
      r.ang_vel_x = 24'(jitter(span));
      r.ang_vel_y = 24'(jitter(span));
      r.ang_vel_z = 24'(jitter(span));
    end
    return r;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < 3; i++) gyro_base[i] = int'($urandom_range(400000)) - 200000;
    for (int i = 0; i < count; i++) send_request(random_item());
  endtask

  // Directed walk through calibration, the stillness states and the special cases.
  task automatic test_directed;
    in_item_t r;
    configure(10, 3, 32768, 1000, 50, 5, 0);
    send_request(make_item(KIND_RESET, 100));
    r = make_item(KIND_ODOM, 101);
    r.lin_vel_x = 24'sh7FFFFF;
    send_request(r);                                     // disturbed calibration
    send_request(make_item(KIND_ODOM, 102));             // first still stamp
    send_request(gyro_item(103, 8388607, -8388608, 0));
    send_request(gyro_item(105, -8388608, 8388607, 1));
    send_request(gyro_item(50, 7, -7, 3));               // before calibration start
    send_request(make_item(KIND_ODOM, 108));
    send_request(gyro_item(120, 12, -12, 5));            // calibration ends, still long
    send_request(gyro_item(121, 300, 200, -100));        // bias average
    send_request(gyro_item(122, 5000, 0, 0));            // deviation forces moving
    send_request(make_item(KIND_ODOM, 130));             // just stopped
    send_request(make_item(KIND_ODOM, 140));             // still long
    send_request(make_item(KIND_ODOM, 135));             // backward stamp
    send_request(make_item(KIND_ODOM, 150));
    send_request(gyro_item(151, -400, 300, 100));
    send_request(make_item(KIND_NONE, 152));             // unknown kind
    send_request(gyro_item(10, 1, 2, 3));                // step back too small to restart
    drain();
    write_reg(REG_SKIP_CALIB, 1);
    send_request(make_item(KIND_RESET, 4000));           // skip straight to moving
    send_request(gyro_item(4001, 8388607, -8388608, -1));
    r = make_item(KIND_ODOM, 4002);
    r.ang_vel_z = 24'sh800000;
    send_request(r);
    send_request(make_item(KIND_ODOM, 4003));
    drain();
  endtask

  // Register extremes: zero thresholds and durations with the largest rate, then the largest values with a zero rate.
  task automatic test_register_extremes;
    configure(0, 1, 131071, 0, 0, 0, 0);
    send_request(make_item(KIND_RESET, 5000));
    send_request(make_item(KIND_ODOM, 5001));
    send_request(make_item(KIND_ODOM, 5002));
    send_request(gyro_item(5003, 77, -77, 0));           // ends at once, still long
    send_request(gyro_item(5004, 77, -77, 0));           // full-weight average
    send_request(gyro_item(5005, 78, -77, 0));           // any deviation moves
    drain();
    configure(TIME_MAX, COUNT_CAP, 0, 8388607, 8388607, TIME_MAX, 0);
    send_request(make_item(KIND_RESET, 6000));
    send_request(gyro_item(6001, 8388607, 8388607, 8388607));
    send_request(make_item(KIND_ODOM, TIME_MAX));
    send_request(gyro_item(TIME_MAX, -8388608, -8388608, -8388608));
    drain();
  endtask

  // Random phases with different idling on each side and different settings.
  task automatic test_random_traffic;
    int idles[4] = '{0, 71, 0, 15};
    int stalls[4] = '{0, 0, 71, 15};
    for (int ph = 0; ph < 4; ph++) begin
      configure($urandom_range(40), $urandom_range(1, 8), $urandom_range(65536),
                $urandom_range(500, 6000), $urandom_range(20, 400), $urandom_range(60),
                $urandom_range(1));
      idle_pct = idles[ph];
      stall_pct = stalls[ph];
      stamp_now = 100 + $urandom_range(1000);
      send_request(make_item(KIND_RESET, stamp_now));
      run_random(360);
      idle_pct = 0;
      stall_pct = 0;
      drain();
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the block fills up and must stall its input.
  task automatic test_backpressure;
    configure(15, 2, 20000, 3000, 200, 20, 0);
    stamp_now = 200;
    send_request(make_item(KIND_RESET, stamp_now));
    @(posedge clk_i);
    hold_cycles = 300;
    run_random(60);
    drain();
  endtask

  initial begin
    cfg_cal_dur = 15000;
    cfg_min_samp = 1000;
    cfg_rate = 655;
    cfg_gyro_th = 3277;
    cfg_vel_th = 66;
    cfg_still_dur = 2000;
    cfg_skip = 0;
    restart_run(0);
    est_mode = MODE_CALIB;
    est_last_arrival = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/gbe_pkg.sv
rtl/core/gyro_bias_estimator_core.sv
tb/tb_gyro_bias_estimator_core.sv
